>>> hdl/gsb_pkg.sv
`default_nettype none

package gsb_pkg;

  // Default canvas and sheet geometry.
  localparam int DEF_CANVAS_WIDTH  = 240;
  localparam int DEF_CANVAS_HEIGHT = 240;
  localparam int DEF_CANVAS_STRIDE = 480;
  localparam int DEF_SHEET_MAX_DIM = 256;

  // Field and internal widths. They cover the full allowed parameter ranges.
  localparam int ROW_W      = 8;
  localparam int COL_W      = 7;
  localparam int PAIR_W     = 8;
  localparam int LEVEL_W    = 4;
  localparam int OFFSET_W   = 17;
  localparam int COLOR_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int DIM_W      = 9;
  localparam int POS_W      = 10;
  localparam int CANVAS_W   = 10;
  localparam int STRIDE_W   = 12;
  localparam int COORD_W    = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_OFFSET_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_OFFSET_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_W      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_H      = 3'd7;

  // Signed coordinate wide enough for every sum and difference in the checks.
  typedef logic signed [COORD_W-1:0] coord_t;

  // One classified byte, as queued between the front and the back.
  typedef struct packed {
    logic                keep_even;
    logic                keep_odd;
    logic [OFFSET_W-1:0] row_base;
    logic [CANVAS_W-1:0] cx_even;
    logic [CANVAS_W-1:0] cx_odd;
    logic [LEVEL_W-1:0]  level_even;
    logic [LEVEL_W-1:0]  level_odd;
  } blit_op_t;

  // Grey level times 17 converted to RGB565. Level times 17 is the nibble doubled.
  function automatic logic [COLOR_W-1:0] grey565(input logic [LEVEL_W-1:0] level);
    logic [7:0] g;
    g = {level, level};
    return {g[7:3], g[7:2], g[7:3]};
  endfunction

endpackage

`default_nettype wire

>>> hdl/gsb_front.sv
`default_nettype none

module gsb_front
  import gsb_pkg::*;
#(
  parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
  parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT,
  parameter int CANVAS_STRIDE = DEF_CANVAS_STRIDE,
  parameter int SHEET_MAX_DIM = DEF_SHEET_MAX_DIM
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [ROW_W-1:0]      source_row,
  input  wire logic [COL_W-1:0]      byte_column,
  input  wire logic [PAIR_W-1:0]     pixel_pair,
  input  wire logic                  queue_full,
  output logic                       push,
  output blit_op_t                   push_op
);

  localparam coord_t CANVAS_W_C  = coord_t'(CANVAS_WIDTH);
  localparam coord_t CANVAS_H_C  = coord_t'(CANVAS_HEIGHT);
  localparam coord_t SHEET_MAX_C = coord_t'(SHEET_MAX_DIM);
  localparam logic [STRIDE_W-1:0] STRIDE_C = STRIDE_W'(CANVAS_STRIDE);

  logic [DIM_W-1:0] sheet_width;
  logic [DIM_W-1:0] sheet_rows;
  logic [POS_W-1:0] dest_offset_x;
  logic [POS_W-1:0] dest_offset_y;
  logic [POS_W-1:0] window_x;
  logic [POS_W-1:0] window_y;
  logic [DIM_W-1:0] window_w;
  logic [DIM_W-1:0] window_h;

  coord_t y, x_even, x_odd;
  coord_t wx, wy, ww, wh, sw, sr, ox, oy;
  coord_t dy, dx_even, dx_odd, cy, cx_even, cx_odd;
  logic   row_ok, keep_even, keep_odd;
  logic [CANVAS_W+STRIDE_W-1:0] row_product;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_width   <= '0;
      sheet_rows    <= '0;
      dest_offset_x <= '0;
      dest_offset_y <= '0;
      window_x      <= '0;
      window_y      <= '0;
      window_w      <= '0;
      window_h      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SHEET_WIDTH:   sheet_width   <= cfg_data[DIM_W-1:0];
        REG_SHEET_ROWS:    sheet_rows    <= cfg_data[DIM_W-1:0];
        REG_DEST_OFFSET_X: dest_offset_x <= cfg_data[POS_W-1:0];
        REG_DEST_OFFSET_Y: dest_offset_y <= cfg_data[POS_W-1:0];
        REG_WINDOW_X:      window_x      <= cfg_data[POS_W-1:0];
        REG_WINDOW_Y:      window_y      <= cfg_data[POS_W-1:0];
        REG_WINDOW_W:      window_w      <= cfg_data[DIM_W-1:0];
        REG_WINDOW_H:      window_h      <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Widen everything to one signed coordinate format.
  always_comb begin
    y       = coord_t'({{(COORD_W-ROW_W){1'b0}}, source_row});
    x_even  = coord_t'({{(COORD_W-COL_W-1){1'b0}}, byte_column, 1'b0});
    x_odd   = coord_t'({{(COORD_W-COL_W-1){1'b0}}, byte_column, 1'b1});
    wx      = coord_t'({{(COORD_W-POS_W){window_x[POS_W-1]}}, window_x});
    wy      = coord_t'({{(COORD_W-POS_W){window_y[POS_W-1]}}, window_y});
    ox      = coord_t'({{(COORD_W-POS_W){dest_offset_x[POS_W-1]}}, dest_offset_x});
    oy      = coord_t'({{(COORD_W-POS_W){dest_offset_y[POS_W-1]}}, dest_offset_y});
    ww      = coord_t'({{(COORD_W-DIM_W){1'b0}}, window_w});
    wh      = coord_t'({{(COORD_W-DIM_W){1'b0}}, window_h});
    sw      = coord_t'({{(COORD_W-DIM_W){1'b0}}, sheet_width});
    sr      = coord_t'({{(COORD_W-DIM_W){1'b0}}, sheet_rows});
    dy      = y - wy;
    dx_even = x_even - wx;
    dx_odd  = x_odd - wx;
    cy      = y + oy;
    cx_even = x_even + ox;
    cx_odd  = x_odd + ox;
  end

  // Row test shared by both pixels, then a test per pixel. A zero window
  // width or height fails the range tests by itself.
  always_comb begin
    row_ok = (dy >= 0) && (dy < wh) && (y < sr) && (y < SHEET_MAX_C)
          && (cy >= 0) && (cy < CANVAS_H_C);
    keep_even = row_ok && (dx_even >= 0) && (dx_even < ww) && (x_even < sw)
             && (x_even < SHEET_MAX_C) && (cx_even >= 0) && (cx_even < CANVAS_W_C);
    keep_odd  = row_ok && (dx_odd >= 0) && (dx_odd < ww) && (x_odd < sw)
             && (x_odd < SHEET_MAX_C) && (cx_odd >= 0) && (cx_odd < CANVAS_W_C);
  end

  // Row start in the framebuffer; the queue register follows the multiplier.
  assign row_product = cy[CANVAS_W-1:0] * STRIDE_C;

  always_comb begin
    push_op.keep_even  = keep_even;
    push_op.keep_odd   = keep_odd;
    push_op.row_base   = OFFSET_W'(row_product);
    push_op.cx_even    = cx_even[CANVAS_W-1:0];
    push_op.cx_odd     = cx_odd[CANVAS_W-1:0];
    push_op.level_even = pixel_pair[PAIR_W-1:LEVEL_W];
    push_op.level_odd  = pixel_pair[LEVEL_W-1:0];
  end

  // Bytes that keep no pixel are accepted and dropped here.
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full && (keep_even || keep_odd);

endmodule

`default_nettype wire

>>> hdl/gsb_queue.sv
`default_nettype none

module gsb_queue
  import gsb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire blit_op_t push_op,
  input  wire logic     pop,
  output logic          full,
  output logic          head_valid,
  output blit_op_t      head_op
);

  localparam int DEPTH = 2;

  blit_op_t slots [DEPTH];
  logic     wr_ptr;
  logic     rd_ptr;
  logic [1:0] count;

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign full       = (count == 2'(DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];

endmodule

`default_nettype wire

>>> hdl/gsb_back.sv
`default_nettype none

module gsb_back
  import gsb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                head_valid,
  input  wire blit_op_t            head_op,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [OFFSET_W-1:0]      pixel_offset,
  output logic [COLOR_W-1:0]       color,
  output logic                     last
);

  logic                load;
  logic                use_odd;
  logic                even_done;
  logic [CANVAS_W-1:0] cx_sel;
  logic [LEVEL_W-1:0]  level_sel;

  // The output register loads whenever it is empty or being taken.
  assign load    = !out_valid || !out_stall;
  assign use_odd = even_done || !head_op.keep_even;
  assign pop     = load && head_valid && (use_odd || !head_op.keep_odd);

  always_comb begin
    cx_sel    = use_odd ? head_op.cx_odd : head_op.cx_even;
    level_sel = use_odd ? head_op.level_odd : head_op.level_even;
  end

  // Control: output valid and the flag that the even pixel has gone out.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      even_done <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        even_done <= !use_odd && head_op.keep_odd;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      pixel_offset <= head_op.row_base
                    + OFFSET_W'({cx_sel, 1'b0});
      color        <= grey565(level_sel);
      last         <= use_odd || !head_op.keep_odd;
    end
  end

endmodule

`default_nettype wire

>>> hdl/grey_sprite_blit_4bpp.sv
`default_nettype none

// Greyscale 4bpp sprite blitter. Each input item is one sheet byte holding two
// pixels (high nibble first); every pixel that lies inside the source window,
// the sheet and, after the destination offset, the canvas leaves as one RGB565
// write with its framebuffer byte offset, even pixel first, last set on the
// final write of the byte. A byte with no visible pixel produces nothing.
// Input items are taken one per cycle while the two-entry queue between the
// classifier and the write stage has room; the write stage issues one result
// per cycle while out_stall is low, one for each visible pixel of a byte.
// An accepted byte is registered in the queue, then in the output register.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
module grey_sprite_blit_4bpp
  import gsb_pkg::*;
#(
  parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
  parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT,
  parameter int CANVAS_STRIDE = DEF_CANVAS_STRIDE,
  parameter int SHEET_MAX_DIM = DEF_SHEET_MAX_DIM
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [ROW_W-1:0]      source_row,
  input  wire logic [COL_W-1:0]      byte_column,
  input  wire logic [PAIR_W-1:0]     pixel_pair,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OFFSET_W-1:0]        pixel_offset,
  output logic [COLOR_W-1:0]         color,
  output logic                       last
);

  logic     push;
  blit_op_t push_op;
  logic     queue_full;
  logic     head_valid;
  blit_op_t head_op;
  logic     pop;

  // Classifier and configuration registers.
  gsb_front #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT),
    .CANVAS_STRIDE (CANVAS_STRIDE),
    .SHEET_MAX_DIM (SHEET_MAX_DIM)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .source_row  (source_row),
    .byte_column (byte_column),
    .pixel_pair  (pixel_pair),
    .queue_full  (queue_full),
    .push        (push),
    .push_op     (push_op)
  );

  // Queue of classified bytes.
  gsb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // Pixel write stage.
  gsb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_op      (head_op),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_offset (pixel_offset),
    .color        (color),
    .last         (last)
  );

  // Every queued byte carries at least one visible pixel.
  a_head_has_pixel: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head_op.keep_even || head_op.keep_odd))
    else $error("queued byte with no visible pixel");

  // A full queue is never empty.
  a_stall_means_queued: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> head_valid)
    else $error("input stalled with an empty queue");

  // Grey output: red and blue fields always agree.
  a_grey_color: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (color[15:11] == color[4:0]))
    else $error("result color is not grey");

  // A result taken without last finds its byte still pending in the queue.
  a_pair_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |-> head_valid)
    else $error("odd pixel missing after a non-final result");

endmodule

`default_nettype wire
